// ===== hdl/ilc_pkg.sv =====
// Shared types, constants and byte class functions for the INI line classifier.
package ilc_pkg;

    localparam int MAX_LINE = 256;
    localparam int COL_W    = $clog2(MAX_LINE + 2);

    localparam logic [2:0] KIND_EMPTY    = 3'd0;
    localparam logic [2:0] KIND_SECTION  = 3'd1;
    localparam logic [2:0] KIND_KEYVAL   = 3'd2;
    localparam logic [2:0] KIND_ERROR    = 3'd3;
    localparam logic [2:0] KIND_OVERLONG = 3'd4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_FIRST_VISIBLE = 8'd33;

    typedef enum logic [11:0] {
        PH_LEAD    = 12'b0000_0000_0001,
        PH_COMMENT = 12'b0000_0000_0010,
        PH_ERROR   = 12'b0000_0000_0100,
        PH_SNAME   = 12'b0000_0000_1000,
        PH_STAIL   = 12'b0000_0001_0000,
        PH_SOK     = 12'b0000_0010_0000,
        PH_KEY     = 12'b0000_0100_0000,
        PH_EQ      = 12'b0000_1000_0000,
        PH_VALUE   = 12'b0001_0000_0000,
        PH_QUOTED  = 12'b0010_0000_0000,
        PH_QTAIL   = 12'b0100_0000_0000,
        PH_VOK     = 12'b1000_0000_0000
    } ilc_phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       finish;
    } ilc_in_t;

    typedef struct packed {
        logic [2:0]  line_kind;
        logic [7:0]  name_offset;
        logic [7:0]  name_length;
        logic [7:0]  value_offset;
        logic [7:0]  value_length;
        logic [15:0] line_number;
    } ilc_out_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_comment(input logic [7:0] b);
        return (b == CH_SEMI) || (b == CH_HASH);
    endfunction

    function automatic logic is_normal(input logic [7:0] b);
        return (b >= CH_FIRST_VISIBLE) && (b != CH_QUOTE) && (b != CH_SEMI) &&
               (b != CH_HASH) && (b != CH_LBRACK) && (b != CH_RBRACK) &&
               (b != CH_EQUAL);
    endfunction

endpackage

// ===== hdl/ilc_parser.sv =====
// Per-byte line parser state and line-end result formation.
module ilc_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  ilc_pkg::ilc_in_t   item,
    output logic               emit,
    output ilc_pkg::ilc_out_t  result
);

    ilc_pkg::ilc_phase_t      phase_reg, phase_next;
    logic [ilc_pkg::COL_W-1:0] column_reg, column_next;
    logic [7:0]  name_begin_reg, name_begin_next;
    logic [7:0]  name_last_reg, name_last_next;
    logic [7:0]  value_begin_reg, value_begin_next;
    logic [7:0]  value_last_reg, value_last_next;
    logic [15:0] line_count_reg, line_count_next;
    logic        nul_reg, nul_next;

    logic [7:0] b;
    logic [7:0] c8;
    logic [7:0] c8_inc;
    logic [7:0] c8_dec;

    assign b      = item.text_byte;
    assign c8     = 8'(column_reg);
    assign c8_inc = c8 + 8'd1;
    assign c8_dec = c8 - 8'd1;

    assign emit = item.finish ? ((column_reg != '0) || nul_reg) : (b == ilc_pkg::CH_LF);

    always_comb begin
        result.line_kind    = ilc_pkg::KIND_ERROR;
        result.name_offset  = 8'd0;
        result.name_length  = 8'd0;
        result.value_offset = 8'd0;
        result.value_length = 8'd0;
        result.line_number  = line_count_reg;
        if (column_reg > ilc_pkg::COL_W'(ilc_pkg::MAX_LINE)) begin
            result.line_kind = ilc_pkg::KIND_OVERLONG;
        end else begin
            case (phase_reg)
                ilc_pkg::PH_LEAD, ilc_pkg::PH_COMMENT: begin
                    result.line_kind = ilc_pkg::KIND_EMPTY;
                end
                ilc_pkg::PH_STAIL, ilc_pkg::PH_SOK: begin
                    result.line_kind   = ilc_pkg::KIND_SECTION;
                    result.name_offset = name_begin_reg;
                    result.name_length = name_last_reg + 8'd1 - name_begin_reg;
                end
                ilc_pkg::PH_VALUE, ilc_pkg::PH_QTAIL, ilc_pkg::PH_VOK: begin
                    result.line_kind    = ilc_pkg::KIND_KEYVAL;
                    result.name_offset  = name_begin_reg;
                    result.name_length  = name_last_reg + 8'd1 - name_begin_reg;
                    result.value_offset = value_begin_reg;
                    result.value_length = value_last_reg + 8'd1 - value_begin_reg;
                end
                default: begin
                    result.line_kind = ilc_pkg::KIND_ERROR;
                end
            endcase
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        column_next      = column_reg;
        name_begin_next  = name_begin_reg;
        name_last_next   = name_last_reg;
        value_begin_next = value_begin_reg;
        value_last_next  = value_last_reg;
        line_count_next  = line_count_reg;
        nul_next         = nul_reg;
        if (step) begin
            if (item.finish || (b == ilc_pkg::CH_LF)) begin
                phase_next       = ilc_pkg::PH_LEAD;
                column_next      = '0;
                name_begin_next  = 8'd0;
                name_last_next   = 8'd0;
                value_begin_next = 8'd0;
                value_last_next  = 8'd0;
                nul_next         = 1'b0;
                if (item.finish || (line_count_reg == 16'hFFFF)) begin
                    line_count_next = 16'd1;
                end else begin
                    line_count_next = line_count_reg + 16'd1;
                end
            end else if ((b == ilc_pkg::CH_CR) || nul_reg) begin
                phase_next = phase_reg;
            end else if (b == ilc_pkg::CH_NUL) begin
                nul_next = 1'b1;
            end else begin
                if (column_reg < ilc_pkg::COL_W'(ilc_pkg::MAX_LINE)) begin
                    case (phase_reg)
                        ilc_pkg::PH_LEAD: begin
                            if (ilc_pkg::is_ws(b)) begin
                                phase_next = ilc_pkg::PH_LEAD;
                            end else if (ilc_pkg::is_comment(b)) begin
                                phase_next = ilc_pkg::PH_COMMENT;
                            end else if (b == ilc_pkg::CH_LBRACK) begin
                                phase_next      = ilc_pkg::PH_SNAME;
                                name_begin_next = c8_inc;
                            end else if (ilc_pkg::is_normal(b)) begin
                                phase_next      = ilc_pkg::PH_KEY;
                                name_begin_next = c8;
                                name_last_next  = c8;
                            end else begin
                                phase_next = ilc_pkg::PH_ERROR;
                            end
                        end
                        ilc_pkg::PH_SNAME: begin
                            if (ilc_pkg::is_normal(b)) begin
                                phase_next = ilc_pkg::PH_SNAME;
                            end else if (b == ilc_pkg::CH_RBRACK) begin
                                phase_next     = ilc_pkg::PH_STAIL;
                                name_last_next = c8_dec;
                            end else begin
                                phase_next = ilc_pkg::PH_ERROR;
                            end
                        end
                        ilc_pkg::PH_STAIL: begin
                            if (!ilc_pkg::is_ws(b)) begin
                                phase_next = ilc_pkg::is_comment(b) ? ilc_pkg::PH_SOK
                                                                    : ilc_pkg::PH_ERROR;
                            end
                        end
                        ilc_pkg::PH_KEY: begin
                            if (ilc_pkg::is_normal(b)) begin
                                name_last_next = c8;
                            end else if (ilc_pkg::is_ws(b)) begin
                                phase_next = ilc_pkg::PH_KEY;
                            end else if (b == ilc_pkg::CH_EQUAL) begin
                                phase_next = ilc_pkg::PH_EQ;
                            end else begin
                                phase_next = ilc_pkg::PH_ERROR;
                            end
                        end
                        ilc_pkg::PH_EQ: begin
                            if (ilc_pkg::is_ws(b)) begin
                                phase_next = ilc_pkg::PH_EQ;
                            end else if (b == ilc_pkg::CH_QUOTE) begin
                                phase_next       = ilc_pkg::PH_QUOTED;
                                value_begin_next = c8_inc;
                            end else if (ilc_pkg::is_normal(b)) begin
                                phase_next       = ilc_pkg::PH_VALUE;
                                value_begin_next = c8;
                                value_last_next  = c8;
                            end else begin
                                phase_next = ilc_pkg::PH_ERROR;
                            end
                        end
                        ilc_pkg::PH_VALUE: begin
                            if (ilc_pkg::is_normal(b)) begin
                                value_last_next = c8;
                            end else if (ilc_pkg::is_ws(b)) begin
                                phase_next = ilc_pkg::PH_VALUE;
                            end else begin
                                phase_next = ilc_pkg::is_comment(b) ? ilc_pkg::PH_VOK
                                                                    : ilc_pkg::PH_ERROR;
                            end
                        end
                        ilc_pkg::PH_QUOTED: begin
                            if (b == ilc_pkg::CH_QUOTE) begin
                                phase_next      = ilc_pkg::PH_QTAIL;
                                value_last_next = c8_dec;
                            end
                        end
                        ilc_pkg::PH_QTAIL: begin
                            if (!ilc_pkg::is_ws(b)) begin
                                phase_next = ilc_pkg::is_comment(b) ? ilc_pkg::PH_VOK
                                                                    : ilc_pkg::PH_ERROR;
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                if (column_reg <= ilc_pkg::COL_W'(ilc_pkg::MAX_LINE)) begin
                    column_next = column_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= ilc_pkg::PH_LEAD;
            column_reg      <= '0;
            name_begin_reg  <= 8'd0;
            name_last_reg   <= 8'd0;
            value_begin_reg <= 8'd0;
            value_last_reg  <= 8'd0;
            line_count_reg  <= 16'd1;
            nul_reg         <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            column_reg      <= column_next;
            name_begin_reg  <= name_begin_next;
            name_last_reg   <= name_last_next;
            value_begin_reg <= value_begin_next;
            value_last_reg  <= value_last_next;
            line_count_reg  <= line_count_next;
            nul_reg         <= nul_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        column_reg <= ilc_pkg::COL_W'(ilc_pkg::MAX_LINE + 1))
        else $error("column ran past the overlong mark");

    assert property (@(posedge aclk) disable iff (!aresetn)
        line_count_reg != 16'd0)
        else $error("line counter reached zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.finish |=> (line_count_reg == 16'd1) && (column_reg == '0) && !nul_reg)
        else $error("finish did not return the parser to its reset state");

endmodule

// ===== hdl/ini_line_classifier_core.sv =====
// INI line classifier top level: input request register, parser, result register.
// Takes one text byte per cycle and reports one result at each line end (newline, or
// finish on a line holding a counted byte or a NUL); the parser result is registered.
// A byte that ends a line waits in the input register only while an earlier result is
// still untaken; other bytes pass through at full rate. Lines longer than MAX_LINE
// counted bytes report as overlong, and offsets and lengths are 8-bit columns.
module ini_line_classifier_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ilc_pkg::ilc_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ilc_pkg::ilc_out_t  m_data
);

    logic              in_valid_reg, in_valid_next;
    ilc_pkg::ilc_in_t  in_data_reg;
    logic              m_valid_reg, m_valid_next;
    ilc_pkg::ilc_out_t m_data_reg;

    logic              emit;
    ilc_pkg::ilc_out_t result;
    logic              out_free;
    logic              advance;

    ilc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .emit    (emit),
        .result  (result)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (out_free || !emit);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // hold the request until the parser takes it
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_data_reg <= result;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.line_kind != ilc_pkg::KIND_KEYVAL)
            |-> (m_data.value_offset == 8'd0) && (m_data.value_length == 8'd0))
        else $error("value fields set on a line that is not a key");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_data.line_kind == ilc_pkg::KIND_EMPTY) ||
                    (m_data.line_kind == ilc_pkg::KIND_ERROR) ||
                    (m_data.line_kind == ilc_pkg::KIND_OVERLONG))
            |-> (m_data.name_offset == 8'd0) && (m_data.name_length == 8'd0))
        else $error("name fields set on a line without a name");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !(advance && emit))
        else $error("result register overwritten while still pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !emit |-> advance)
        else $error("byte without a line end stalled in the input register");

endmodule

// ===== verif/tb_ini_line_classifier_core.sv =====
// Testbench for the INI line classifier core: directed and random text checked line by line.
`timescale 1ns / 100ps

module tb_ini_line_classifier_core;

    typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALL, PACE_BOTH} pace_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    ilc_pkg::ilc_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    ilc_pkg::ilc_out_t m_data;

    ini_line_classifier_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // line parser state
    ilc_pkg::ilc_phase_t cur_phase = ilc_pkg::PH_LEAD;
    int unsigned col       = 0;
    logic [7:0]  nm_begin  = '0;
    logic [7:0]  nm_last   = '0;
    logic [7:0]  val_begin = '0;
    logic [7:0]  val_last  = '0;
    logic [15:0] line_no   = 16'd1;
    bit          nul_hit   = 1'b0;

    ilc_pkg::ilc_out_t expected_lines[$];
    logic [7:0] line_q[$];
    int         send_gap_pct   = 0;
    int         recv_stall_pct = 0;
    int         fail_count     = 0;
    int         req_count      = 0;
    int         kind_seen[5]   = '{default: 0};

    function automatic bit blank_byte(input logic [7:0] b);
        return (b == ilc_pkg::CH_SPACE) || (b == ilc_pkg::CH_TAB);
    endfunction

    function automatic bit remark_byte(input logic [7:0] b);
        return (b == ilc_pkg::CH_SEMI) || (b == ilc_pkg::CH_HASH);
    endfunction

    function automatic bit plain_byte(input logic [7:0] b);
        return (b >= ilc_pkg::CH_FIRST_VISIBLE) && (b != ilc_pkg::CH_QUOTE) &&
               (b != ilc_pkg::CH_SEMI) && (b != ilc_pkg::CH_HASH) &&
               (b != ilc_pkg::CH_LBRACK) && (b != ilc_pkg::CH_RBRACK) &&
               (b != ilc_pkg::CH_EQUAL);
    endfunction

    function automatic void clear_parser();
        cur_phase = ilc_pkg::PH_LEAD;
        col       = 0;
        nm_begin  = '0;
        nm_last   = '0;
        val_begin = '0;
        val_last  = '0;
        nul_hit   = 1'b0;
    endfunction

    function automatic void advance_phase(input logic [7:0] b);
        logic [7:0] here;
        logic [7:0] ahead;
        logic [7:0] behind;
        here   = col[7:0];
        ahead  = here + 8'd1;
        behind = here - 8'd1;
        case (cur_phase)
            ilc_pkg::PH_LEAD: begin
                if (remark_byte(b)) cur_phase = ilc_pkg::PH_COMMENT;
                else if (b == ilc_pkg::CH_LBRACK) begin
                    cur_phase = ilc_pkg::PH_SNAME;
                    nm_begin  = ahead;
                end else if (plain_byte(b)) begin
                    cur_phase = ilc_pkg::PH_KEY;
                    nm_begin  = here;
                    nm_last   = here;
                end else if (!blank_byte(b)) cur_phase = ilc_pkg::PH_ERROR;
            end
            ilc_pkg::PH_SNAME: begin
                if (b == ilc_pkg::CH_RBRACK) begin
                    cur_phase = ilc_pkg::PH_STAIL;
                    nm_last   = behind;
                end else if (!plain_byte(b)) cur_phase = ilc_pkg::PH_ERROR;
            end
            ilc_pkg::PH_STAIL: begin
                if (!blank_byte(b))
                    cur_phase = remark_byte(b) ? ilc_pkg::PH_SOK : ilc_pkg::PH_ERROR;
            end
            ilc_pkg::PH_KEY: begin
                if (plain_byte(b)) nm_last = here;
                else if (b == ilc_pkg::CH_EQUAL) cur_phase = ilc_pkg::PH_EQ;
                else if (!blank_byte(b)) cur_phase = ilc_pkg::PH_ERROR;
            end
            ilc_pkg::PH_EQ: begin
                if (b == ilc_pkg::CH_QUOTE) begin
                    cur_phase = ilc_pkg::PH_QUOTED;
                    val_begin = ahead;
                end else if (plain_byte(b)) begin
                    cur_phase = ilc_pkg::PH_VALUE;
                    val_begin = here;
                    val_last  = here;
                end else if (!blank_byte(b)) cur_phase = ilc_pkg::PH_ERROR;
            end
            ilc_pkg::PH_VALUE: begin
                if (plain_byte(b)) val_last = here;
                else if (remark_byte(b)) cur_phase = ilc_pkg::PH_VOK;
                else if (!blank_byte(b)) cur_phase = ilc_pkg::PH_ERROR;
            end
            ilc_pkg::PH_QUOTED: begin
                if (b == ilc_pkg::CH_QUOTE) begin
                    cur_phase = ilc_pkg::PH_QTAIL;
                    val_last  = behind;
                end
            end
            ilc_pkg::PH_QTAIL: begin
                if (!blank_byte(b))
                    cur_phase = remark_byte(b) ? ilc_pkg::PH_VOK : ilc_pkg::PH_ERROR;
            end
            default: ;
        endcase
    endfunction

    function automatic void close_line(output ilc_pkg::ilc_out_t res);
        res = '0;
        if (col > ilc_pkg::MAX_LINE) begin
            res.line_kind = ilc_pkg::KIND_OVERLONG;
        end else begin
            case (cur_phase)
                ilc_pkg::PH_LEAD, ilc_pkg::PH_COMMENT: res.line_kind = ilc_pkg::KIND_EMPTY;
                ilc_pkg::PH_STAIL, ilc_pkg::PH_SOK: begin
                    res.line_kind   = ilc_pkg::KIND_SECTION;
                    res.name_offset = nm_begin;
                    res.name_length = nm_last + 8'd1 - nm_begin;
                end
                ilc_pkg::PH_VALUE, ilc_pkg::PH_QTAIL, ilc_pkg::PH_VOK: begin
                    res.line_kind    = ilc_pkg::KIND_KEYVAL;
                    res.name_offset  = nm_begin;
                    res.name_length  = nm_last + 8'd1 - nm_begin;
                    res.value_offset = val_begin;
                    res.value_length = val_last + 8'd1 - val_begin;
                end
                default: res.line_kind = ilc_pkg::KIND_ERROR;
            endcase
        end
        res.line_number = line_no;
        line_no = (line_no == 16'hFFFF) ? 16'd1 : line_no + 16'd1;
        clear_parser();
    endfunction

    function automatic bit parse_byte(input ilc_pkg::ilc_in_t req,
                                      output ilc_pkg::ilc_out_t res);
        bit has_line;
        has_line = 1'b0;
        res = '0;
        if (req.finish) begin
            if (col != 0 || nul_hit) begin
                close_line(res);
                has_line = 1'b1;
            end
            clear_parser();
            line_no = 16'd1;
            return has_line;
        end
        if (req.text_byte == ilc_pkg::CH_LF) begin
            close_line(res);
            return 1'b1;
        end
        if (req.text_byte == ilc_pkg::CH_CR || nul_hit) return 1'b0;
        if (req.text_byte == ilc_pkg::CH_NUL) begin
            nul_hit = 1'b1;
            return 1'b0;
        end
        if (col < ilc_pkg::MAX_LINE) advance_phase(req.text_byte);
        if (col <= ilc_pkg::MAX_LINE) col++;
        return 1'b0;
    endfunction

    task automatic check_field(input string fname, input logic [15:0] want_v,
                               input logic [15:0] got_v, input logic [15:0] line);
        if (want_v !== got_v) begin
            fail_count++;
            $display("%0t: line %0d %s expected %0d actual %0d",
                     $time, line, fname, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin : watch
        ilc_pkg::ilc_out_t predicted;
        ilc_pkg::ilc_out_t oldest;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                req_count++;
                if (parse_byte(s_data, predicted)) expected_lines.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (expected_lines.size() == 0) begin
                    fail_count++;
                    $display("%0t: result expected none actual kind %0d line %0d",
                             $time, m_data.line_kind, m_data.line_number);
                end else begin
                    oldest = expected_lines.pop_front();
                    check_field("line_kind", oldest.line_kind, m_data.line_kind,
                                oldest.line_number);
                    check_field("name_offset", oldest.name_offset, m_data.name_offset,
                                oldest.line_number);
                    check_field("name_length", oldest.name_length, m_data.name_length,
                                oldest.line_number);
                    check_field("value_offset", oldest.value_offset, m_data.value_offset,
                                oldest.line_number);
                    check_field("value_length", oldest.value_length, m_data.value_length,
                                oldest.line_number);
                    check_field("line_number", oldest.line_number, m_data.line_number,
                                oldest.line_number);
                    if (m_data.line_kind <= ilc_pkg::KIND_OVERLONG)
                        kind_seen[m_data.line_kind]++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_pace(input pace_t p);
        case (p)
            PACE_FULL:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_GAPS:  begin send_gap_pct = 67; recv_stall_pct = 0;  end
            PACE_RECV_STALL: begin send_gap_pct = 0;  recv_stall_pct = 67; end
            default:         begin send_gap_pct = 21; recv_stall_pct = 21; end
        endcase
    endtask

    task automatic send_req(input logic [7:0] b, input logic fin);
        ilc_pkg::ilc_in_t r;
        r.text_byte = b;
        r.finish    = fin;
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
    endtask

    task automatic send_repeat(input logic [7:0] b, input int n);
        repeat (n) send_req(b, 1'b0);
    endtask

    task automatic send_finish();
        send_req(8'($urandom), 1'b1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_lines.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(33, 255)); while (!plain_byte(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(1) ? ilc_pkg::CH_SPACE : ilc_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] pick_free(input bit quoted);
        logic [7:0] b;
        do b = 8'($urandom);
        while (b == ilc_pkg::CH_LF ||
               (quoted && (b == ilc_pkg::CH_QUOTE || b == ilc_pkg::CH_NUL)));
        return b;
    endfunction

    function automatic void add_blanks(input int maxn);
        repeat ($urandom_range(maxn)) line_q.push_back(pick_blank());
    endfunction

    function automatic void add_word(input int maxn, input bit inner);
        int n;
        n = $urandom_range(1, maxn);
        line_q.push_back(pick_plain());
        repeat (n - 1)
            line_q.push_back((inner && $urandom_range(3) == 0) ? pick_blank() : pick_plain());
    endfunction

    function automatic void add_tail();
        add_blanks(2);
        if ($urandom_range(2) == 0) begin
            line_q.push_back($urandom_range(1) ? ilc_pkg::CH_SEMI : ilc_pkg::CH_HASH);
            repeat ($urandom_range(6)) line_q.push_back(pick_free(1'b0));
        end
    endfunction

    function automatic void build_line();
        int pick;
        line_q.delete();
        pick = $urandom_range(99);
        add_blanks(2);
        if (pick < 10) begin
            add_tail();
        end else if (pick < 25) begin
            line_q.push_back(ilc_pkg::CH_LBRACK);
            if ($urandom_range(4) != 0) add_word(6, 1'b0);
            line_q.push_back(ilc_pkg::CH_RBRACK);
            add_tail();
        end else if (pick < 80) begin
            add_word(6, 1'b1);
            add_blanks(2);
            line_q.push_back(ilc_pkg::CH_EQUAL);
            add_blanks(2);
            if (pick < 60) begin
                add_word(8, 1'b1);
            end else begin
                line_q.push_back(ilc_pkg::CH_QUOTE);
                repeat ($urandom_range(8)) line_q.push_back(pick_free(1'b1));
                line_q.push_back(ilc_pkg::CH_QUOTE);
            end
            add_tail();
        end else if (pick < 90) begin
            repeat ($urandom_range(12)) line_q.push_back(pick_free(1'b0));
        end else begin
            add_word(4, 1'b0);
            line_q.push_back(ilc_pkg::CH_EQUAL);
            add_word(4, 1'b0);
            line_q.push_back(ilc_pkg::CH_NUL);
            repeat ($urandom_range(6)) line_q.push_back(pick_free(1'b0));
        end
        // corrupt one byte
        if (line_q.size() != 0 && $urandom_range(99) < 15)
            line_q[$urandom_range(line_q.size() - 1)] = pick_free(1'b0);
        if ($urandom_range(99) < 8)
            line_q.insert($urandom_range(line_q.size()), ilc_pkg::CH_CR);
    endfunction

    task automatic test_line_kinds();
        send_text("\n");
        send_text("  \t\n");
        send_text("; note\n");
        send_text("# note\n");
        send_text("[core]\n");
        send_text(" [] ; x\n");
        send_text("[a.b]\t\n");
        send_text("key=value\n");
        send_text("\tmy key \t= some  value \t; c\n");
        send_text("q = \"[x];= #y\"  # c\n");
        send_text("k=\"\"\n");
        send_text("k=v#c\n");
        send_req(8'hFF, 1'b0);
        send_req(ilc_pkg::CH_EQUAL, 1'b0);
        send_req(8'h80, 1'b0);
        send_text("\n");
        drain();
    endtask

    task automatic test_syntax_errors();
        send_text("=v\n");
        send_text("k=\n");
        send_text("k = ;c\n");
        send_text("[a b]\n");
        send_text("[a]x\n");
        send_text("[sec\n");
        send_text("\"q\"=1\n");
        send_text("k=\"open\n");
        send_text("k=\"v\"x\n");
        send_text("k=a\"b\n");
        send_text("k v x\n");
        send_req(8'h01, 1'b0);
        send_text("k=v\n");
        drain();
    endtask

    task automatic test_nul_and_cr();
        send_text("k=v");
        send_req(ilc_pkg::CH_NUL, 1'b0);
        send_text("j\"[\r\n");
        send_req(ilc_pkg::CH_NUL, 1'b0);
        send_text("\n");
        send_text("k\r=\rv\r\n");
        send_finish();
        send_text("\r");
        send_finish();
        send_req(ilc_pkg::CH_NUL, 1'b0);
        send_finish();
        send_text("a=b");
        send_finish();
        send_text("x=y\n");
        drain();
    endtask

    task automatic test_line_limits();
        // one counted byte past the column limit, closed by finish
        send_text("[x]");
        send_repeat(ilc_pkg::CH_SPACE, 254);
        send_finish();
        drain();
    endtask

    task automatic test_random_traffic(input pace_t p);
        int sent;
        int lines;
        set_pace(p);
        sent  = 0;
        lines = 0;
        while (sent < 50 || lines < 5) begin
            build_line();
            foreach (line_q[i]) send_req(line_q[i], 1'b0);
            if ($urandom_range(99) < 6) send_finish();
            else send_req(ilc_pkg::CH_LF, 1'b0);
            sent += line_q.size() + 1;
            lines++;
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_pace(PACE_BOTH);
        test_line_kinds();
        test_syntax_errors();
        test_nul_and_cr();
        test_line_limits();
        test_random_traffic(PACE_FULL);
        test_random_traffic(PACE_SEND_GAPS);
        test_random_traffic(PACE_RECV_STALL);
        test_random_traffic(PACE_BOTH);
        if (expected_lines.size() != 0) begin
            fail_count++;
            $display("%0t: results expected %0d more actual 0", $time, expected_lines.size());
        end
        $display("covered %0d requests at full rate, with sender gaps, receiver stalls and both",
                 req_count);
        $display("line results: %0d empty, %0d section, %0d key, %0d error, %0d overlong",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (fail_count == 0) begin
            $display("ini_line_classifier_core: match");
        end else begin
            $display("ini_line_classifier_core: mismatch");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("ini_line_classifier_core: mismatch");
        $finish;
    end

endmodule
